[rtl/core/bcf_pkg.sv]
// ----------------------------------------------------------------------------
// bcf_pkg: shared types and constants for the box/frustum classifier
// Fixed-point widths, per-stage payload structs, verdict codes and the
// stage control struct that travels between pipeline modules.
// ----------------------------------------------------------------------------
package bcf_pkg;

  // Q16.16 operands, exact Q32.32 products, Q33.32 partial and Q34.32 corner sums
  localparam int CoordW      = 32;
  localparam int FracBits    = 16;
  localparam int ProdW       = 2 * CoordW;
  localparam int PartW       = ProdW + 1;
  localparam int SumW        = PartW + 1;
  localparam int CornerCount = 8;

  typedef logic signed [CoordW-1:0] coord_t;

  // Verdict codes
  typedef enum logic [1:0] {
    VERDICT_OUTSIDE = 2'd0,
    VERDICT_INSIDE  = 2'd1,
    VERDICT_PARTIAL = 2'd2
  } verdict_t;

  // Per-stage occupancy and last-plane mark
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  // One registered request: plane and box
  typedef struct packed {
    coord_t a;
    coord_t b;
    coord_t c;
    coord_t d;
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } item_t;

  // Coefficient times coordinate, index 0 = min, 1 = max
  typedef struct packed {
    coord_t                 d;
    logic [1:0][ProdW-1:0]  ax;
    logic [1:0][ProdW-1:0]  by;
    logic [1:0][ProdW-1:0]  cz;
  } prod_t;

  // xd[i] = a*x_i + d*2^16, yz[j] = b*y_(j&1) + c*z_(j>>1)
  typedef struct packed {
    logic [1:0][PartW-1:0]  xd;
    logic [3:0][PartW-1:0]  yz;
  } part_t;

  typedef logic [CornerCount-1:0] corner_mask_t;

endpackage

[rtl/core/box_corner_frustum_classify.sv]
// Stages: input register, 32x32 multipliers, partial sums, corner signs.
// Throughput: one plane request per cycle; the pipe stalls only when a verdict
// waits in the output register, the sign stage holds a last plane and all four
// stages are full. The sign stage feeds the verdict into the output register.
// Reset (rst, synchronous): empties all stages, drops out_valid and returns the
// reject flag to 0 and the all-inside flag to 1.
// ----------------------------------------------------------------------------
// box_corner_frustum_classify: box against clip plane classifier
// Streams one plane per request and gives outside, inside or partial for the
// box on the plane that carries the last mark.
// ----------------------------------------------------------------------------
module box_corner_frustum_classify (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  plane_a,
  input  logic signed [31:0]  plane_b,
  input  logic signed [31:0]  plane_c,
  input  logic signed [31:0]  plane_offset,
  input  logic signed [31:0]  box_min_x,
  input  logic signed [31:0]  box_min_y,
  input  logic signed [31:0]  box_min_z,
  input  logic signed [31:0]  box_max_x,
  input  logic signed [31:0]  box_max_y,
  input  logic signed [31:0]  box_max_z,
  input  logic                last_plane,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          verdict
);

  bcf_pkg::stage_ctl_t   in_ctl, mul_ctl, part_ctl, sign_ctl;
  bcf_pkg::item_t        item;
  bcf_pkg::prod_t        prod;
  bcf_pkg::part_t        part;
  bcf_pkg::corner_mask_t mask;
  logic                  sign_ready;
  logic                  part_ready;
  logic                  mul_ready;

  // Elastic ready chain: a stage loads when empty or when it drains
  assign part_ready = ~part_ctl.valid | sign_ready;
  assign mul_ready  = ~mul_ctl.valid | part_ready;
  assign in_ready   = ~in_ctl.valid | mul_ready;

  // Stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_ctl   <= '0;
      mul_ctl  <= '0;
      part_ctl <= '0;
      sign_ctl <= '0;
    end else begin
      if (in_ready) begin
        in_ctl.valid <= in_valid;
        in_ctl.last  <= last_plane;
      end
      if (mul_ready) begin
        mul_ctl <= in_ctl;
      end
      if (part_ready) begin
        part_ctl <= mul_ctl;
      end
      if (sign_ready) begin
        sign_ctl <= part_ctl;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.a     <= plane_a;
      item.b     <= plane_b;
      item.c     <= plane_c;
      item.d     <= plane_offset;
      item.min_x <= box_min_x;
      item.min_y <= box_min_y;
      item.min_z <= box_min_z;
      item.max_x <= box_max_x;
      item.max_y <= box_max_y;
      item.max_z <= box_max_z;
    end
  end

  bcf_mul u_mul (
    .clk  (clk),
    .en   (in_ctl.valid & mul_ready),
    .item (item),
    .prod (prod)
  );

  bcf_partial u_partial (
    .clk  (clk),
    .en   (mul_ctl.valid & part_ready),
    .prod (prod),
    .part (part)
  );

  bcf_sign u_sign (
    .clk  (clk),
    .en   (part_ctl.valid & sign_ready),
    .part (part),
    .mask (mask)
  );

  bcf_verdict u_verdict (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sign_ctl),
    .mask      (mask),
    .take      (sign_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .verdict   (verdict)
  );

endmodule

[rtl/core/bcf_mul.sv]
// ----------------------------------------------------------------------------
// bcf_mul: coefficient by coordinate products
// Forms the six exact 32x32 signed products shared by the eight corners
// and registers them together with the plane offset.
// ----------------------------------------------------------------------------
module bcf_mul (
  input  logic           clk,
  input  logic           en,
  input  bcf_pkg::item_t item,
  output bcf_pkg::prod_t prod
);

  logic signed [bcf_pkg::ProdW-1:0] ax0, ax1, by0, by1, cz0, cz1;

  // One multiplier per axis and corner value
  always_comb begin
    ax0 = item.a * item.min_x;
    ax1 = item.a * item.max_x;
    by0 = item.b * item.min_y;
    by1 = item.b * item.max_y;
    cz0 = item.c * item.min_z;
    cz1 = item.c * item.max_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod.d     <= item.d;
      prod.ax[0] <= ax0;
      prod.ax[1] <= ax1;
      prod.by[0] <= by0;
      prod.by[1] <= by1;
      prod.cz[0] <= cz0;
      prod.cz[1] <= cz1;
    end
  end

endmodule

[rtl/core/bcf_partial.sv]
// ----------------------------------------------------------------------------
// bcf_partial: partial sums of the plane distance
// Adds the scaled offset to each x product and forms the four y/z sums,
// so each corner needs a single add in the next stage.
// ----------------------------------------------------------------------------
module bcf_partial (
  input  logic           clk,
  input  logic           en,
  input  bcf_pkg::prod_t prod,
  output bcf_pkg::part_t part
);

  logic signed [bcf_pkg::PartW-1:0] off_q;
  logic signed [bcf_pkg::PartW-1:0] xd [2];
  logic signed [bcf_pkg::PartW-1:0] yz [4];

  // Offset d moved from Q16.16 to Q32.32
  assign off_q = bcf_pkg::PartW'(prod.d) <<< bcf_pkg::FracBits;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      xd[i] = bcf_pkg::PartW'($signed(prod.ax[i])) + off_q;
    end
    for (int j = 0; j < 4; j++) begin
      yz[j] = bcf_pkg::PartW'($signed(prod.by[j % 2])) +
              bcf_pkg::PartW'($signed(prod.cz[j / 2]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        part.xd[i] <= xd[i];
      end
      for (int j = 0; j < 4; j++) begin
        part.yz[j] <= yz[j];
      end
    end
  end

endmodule

[rtl/core/bcf_sign.sv]
// ----------------------------------------------------------------------------
// bcf_sign: per-corner inside test
// Completes the signed distance of each of the eight corners and
// registers a mask of the corners that are not below the plane.
// ----------------------------------------------------------------------------
module bcf_sign (
  input  logic                  clk,
  input  logic                  en,
  input  bcf_pkg::part_t        part,
  output bcf_pkg::corner_mask_t mask
);

  bcf_pkg::corner_mask_t corner_in;

  // Corner k takes x from bit 0, y from bit 1, z from bit 2
  for (genvar k = 0; k < bcf_pkg::CornerCount; k++) begin : g_corner
    logic signed [bcf_pkg::SumW-1:0] corner_sum;
    assign corner_sum = bcf_pkg::SumW'($signed(part.xd[k % 2])) +
                        bcf_pkg::SumW'($signed(part.yz[k / 2]));
    assign corner_in[k] = ~corner_sum[bcf_pkg::SumW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mask <= corner_in;
    end
  end

endmodule

[rtl/core/bcf_verdict.sv]
// ----------------------------------------------------------------------------
// bcf_verdict: query flags and result register
// Folds each plane's corner mask into the sticky reject and all-inside
// flags and loads the verdict into the output register on the last plane.
// ----------------------------------------------------------------------------
module bcf_verdict (
  input  logic                  clk,
  input  logic                  rst,
  input  bcf_pkg::stage_ctl_t   ctl,
  input  bcf_pkg::corner_mask_t mask,
  output logic                  take,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            verdict
);

  logic              rejected_seen;
  logic              all_inside;
  logic              rejected_next;
  logic              all_inside_next;
  logic              fire;
  bcf_pkg::verdict_t result;
  bcf_pkg::verdict_t result_next;

  // A plane without the last mark never waits on the output side
  assign take = ~ctl.valid | ~ctl.last | ~out_valid | out_ready;
  assign fire = ctl.valid & take;

  // Flag update and verdict for the plane at the head of the pipe
  always_comb begin
    rejected_next   = rejected_seen | (mask == '0);
    all_inside_next = all_inside & (&mask);
    if (rejected_next) begin
      result_next = bcf_pkg::VERDICT_OUTSIDE;
    end else if (all_inside_next) begin
      result_next = bcf_pkg::VERDICT_INSIDE;
    end else begin
      result_next = bcf_pkg::VERDICT_PARTIAL;
    end
  end

  // Flags and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rejected_seen <= 1'b0;
      all_inside    <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        if (ctl.last) begin
          out_valid     <= 1'b1;
          rejected_seen <= 1'b0;
          all_inside    <= 1'b1;
        end else begin
          rejected_seen <= rejected_next;
          all_inside    <= all_inside_next;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire && ctl.last) begin
      result <= result_next;
    end
  end

  assign verdict = result;

  // Flags return to their idle values after every verdict
  a_flags_clear: assert property (@(posedge clk) disable iff (rst)
    (fire && ctl.last) |=> (!rejected_seen && all_inside))
    else $error("query flags not cleared after verdict");

  // A rejecting plane sets the sticky flag
  a_reject_sticky: assert property (@(posedge clk) disable iff (rst)
    (fire && !ctl.last && mask == '0) |=> rejected_seen)
    else $error("rejecting plane did not set reject flag");

  // A rejected query can never also be fully inside
  a_flag_consistent: assert property (@(posedge clk) disable iff (rst)
    rejected_seen |-> !all_inside)
    else $error("reject and all-inside flags both set");

  // Only defined verdict codes leave the block
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result == bcf_pkg::VERDICT_OUTSIDE ||
                   result == bcf_pkg::VERDICT_INSIDE ||
                   result == bcf_pkg::VERDICT_PARTIAL))
    else $error("undefined verdict code presented");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for box_corner_frustum_classify
// Streams plane requests (directed corner cases, then random queries of mixed
// scale) with random idle on both sides and one long output hold-off. A
// scoreboard class predicts each verdict with exact 128-bit distance sums.
// ----------------------------------------------------------------------------
module tb;

  localparam int              IdlePct    = 38;
  localparam int              HoldCycles = 250;
  localparam int              StallLimit = 4000;
  localparam int              ItemTarget = 1950;
  localparam bcf_pkg::coord_t One        = 32'sh0001_0000;
  localparam bcf_pkg::coord_t MaxV       = 32'sh7fff_ffff;
  localparam bcf_pkg::coord_t MinV       = 32'sh8000_0000;

  // Verdict predictor and in-order checker
  class verdict_scoreboard;
    bit                 plane_rejected;
    bit                 every_corner_in;
    bcf_pkg::verdict_t  pending[$];
    int unsigned        errors;

    function new();
      plane_rejected  = 1'b0;
      every_corner_in = 1'b1;
      errors          = 0;
    endfunction

    // Exact sign test of a*x + b*y + c*z + d*2^16
    function bit corner_clear(bcf_pkg::coord_t a, bcf_pkg::coord_t b,
                              bcf_pkg::coord_t c, bcf_pkg::coord_t d,
                              bcf_pkg::coord_t x, bcf_pkg::coord_t y,
                              bcf_pkg::coord_t z);
      logic signed [127:0] wa, wb, wc, wd, wx, wy, wz, dist_sum;
      wa = a; wb = b; wc = c; wd = d;
      wx = x; wy = y; wz = z;
      dist_sum = wa * wx + wb * wy + wc * wz + (wd <<< bcf_pkg::FracBits);
      return ~dist_sum[127];
    endfunction

    function void note_request(bcf_pkg::item_t req, logic last);
      int unsigned     clear_count;
      bcf_pkg::coord_t x, y, z;
      clear_count = 0;
      for (int k = 0; k < bcf_pkg::CornerCount; k++) begin
        x = k[0] ? req.max_x : req.min_x;
        y = k[1] ? req.max_y : req.min_y;
        z = k[2] ? req.max_z : req.min_z;
        if (corner_clear(req.a, req.b, req.c, req.d, x, y, z)) clear_count++;
      end
      if (clear_count == 0) plane_rejected = 1'b1;
      if (clear_count != bcf_pkg::CornerCount) every_corner_in = 1'b0;
      if (last) begin
        if (plane_rejected) pending.push_back(bcf_pkg::VERDICT_OUTSIDE);
        else if (every_corner_in) pending.push_back(bcf_pkg::VERDICT_INSIDE);
        else pending.push_back(bcf_pkg::VERDICT_PARTIAL);
        plane_rejected  = 1'b0;
        every_corner_in = 1'b1;
      end
    endfunction

    function void check_verdict(logic [1:0] got);
      bcf_pkg::verdict_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, got %0d", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: verdict mismatch, expected %0d (%s), got %0d",
                 $time, want, want.name(), got);
        errors++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  bcf_pkg::coord_t plane_a, plane_b, plane_c, plane_offset;
  bcf_pkg::coord_t box_min_x, box_min_y, box_min_z;
  bcf_pkg::coord_t box_max_x, box_max_y, box_max_z;
  logic            last_plane;
  logic            out_valid;
  logic            out_ready;
  logic [1:0]      verdict;

  verdict_scoreboard sb = new();
  int          idle_pct     = IdlePct;
  bit          hold_request = 1'b0;
  int unsigned stall_cycles = 0;
  int unsigned sent_count   = 0;

  box_corner_frustum_classify dut (.*);

  // Clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_verdict(verdict);
  end

  // Cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("%0t: no handshake for %0d cycles", $time, StallLimit);
    $display("simulation failed");
    $finish;
  end

  // Receiver: random back-pressure plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  function automatic bcf_pkg::item_t make_item(
      bcf_pkg::coord_t a, bcf_pkg::coord_t b, bcf_pkg::coord_t c, bcf_pkg::coord_t d,
      bcf_pkg::coord_t mnx, bcf_pkg::coord_t mny, bcf_pkg::coord_t mnz,
      bcf_pkg::coord_t mxx, bcf_pkg::coord_t mxy, bcf_pkg::coord_t mxz);
    bcf_pkg::item_t it;
    it.a = a; it.b = b; it.c = c; it.d = d;
    it.min_x = mnx; it.min_y = mny; it.min_z = mnz;
    it.max_x = mxx; it.max_y = mxy; it.max_z = mxz;
    return it;
  endfunction

  // mode 0: full range, 1: small values of the given span, 2: edge values
  function automatic bcf_pkg::coord_t rand_field(int mode, int span_bits);
    case (mode)
      0: return bcf_pkg::coord_t'($urandom);
      1: return bcf_pkg::coord_t'(int'($urandom_range(2 << span_bits)) -
                                  (1 << span_bits));
      default: begin
        case ($urandom_range(4))
          0: return MinV;
          1: return MaxV;
          2: return '0;
          3: return '1;
          default: return One;
        endcase
      end
    endcase
  endfunction

  function automatic int pick_mode();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 1;
    if (r < 85) return 0;
    return 2;
  endfunction

  // Drive one plane request and wait for it to be taken
  task automatic send_plane(input bcf_pkg::item_t req, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    plane_a      <= req.a;
    plane_b      <= req.b;
    plane_c      <= req.c;
    plane_offset <= req.d;
    box_min_x    <= req.min_x;
    box_min_y    <= req.min_y;
    box_min_z    <= req.min_z;
    box_max_x    <= req.max_x;
    box_max_y    <= req.max_y;
    box_max_z    <= req.max_z;
    last_plane   <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, last);
    sent_count++;
  endtask

  task automatic send_random_query();
    int             mode, planes;
    bcf_pkg::item_t box, req;
    mode   = pick_mode();
    planes = ($urandom_range(9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
    box = make_item('0, '0, '0, '0,
                    rand_field(mode, 12), rand_field(mode, 12), rand_field(mode, 12),
                    rand_field(mode, 12), rand_field(mode, 12), rand_field(mode, 12));
    for (int p = 0; p < planes; p++) begin
      // occasionally the box changes within the query
      if ($urandom_range(9) == 0)
        box = make_item('0, '0, '0, '0,
                        rand_field(mode, 12), rand_field(mode, 12), rand_field(mode, 12),
                        rand_field(mode, 12), rand_field(mode, 12), rand_field(mode, 12));
      req   = box;
      req.a = rand_field(mode, 12);
      req.b = rand_field(mode, 12);
      req.c = rand_field(mode, 12);
      req.d = rand_field(mode, 10);
      send_plane(req, p == planes - 1);
    end
  endtask

  // Main sequence
  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    plane_a      <= '0;
    plane_b      <= '0;
    plane_c      <= '0;
    plane_offset <= '0;
    box_min_x    <= '0;
    box_min_y    <= '0;
    box_min_z    <= '0;
    box_max_x    <= '0;
    box_max_y    <= '0;
    box_max_z    <= '0;
    last_plane   <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Zero distance counts as inside; smallest negative offset is outside
    send_plane(make_item('0, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b1);
    send_plane(make_item('0, '0, '0, '1, '0, '0, '0, '0, '0, '0), 1'b1);
    send_plane(make_item('0, '0, '0, MaxV, MinV, MinV, MinV, MaxV, MaxV, MaxV), 1'b1);
    // Plane through the box
    send_plane(make_item(One, '0, '0, '0, -One, '0, '0, One, '0, '0), 1'b1);
    // Largest magnitudes
    send_plane(make_item(MinV, MinV, MinV, MinV, MinV, MinV, MinV, MaxV, MaxV, MaxV), 1'b1);
    send_plane(make_item(MaxV, MaxV, MaxV, MaxV, MaxV, MaxV, MaxV, MaxV, MaxV, MaxV), 1'b1);
    send_plane(make_item(MinV, MinV, MinV, MinV, MaxV, MaxV, MaxV, MaxV, MaxV, MaxV), 1'b1);
    send_plane(make_item(MinV, MinV, MinV, MinV, MinV, MinV, MinV, MinV, MinV, MinV), 1'b1);
    send_plane(make_item('1, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1'b1);
    // Swapped min and max corners
    send_plane(make_item(One, '0, '0, '0, One, '0, '0, -One, '0, '0), 1'b1);
    // Reject on an early plane sticks through the last one
    send_plane(make_item('0, '0, '0, -One, '0, '0, '0, '0, '0, '0), 1'b0);
    send_plane(make_item('0, '0, '0, One, '0, '0, '0, '0, '0, '0), 1'b1);
    // Flags clear after the verdict
    send_plane(make_item('0, '0, '0, One, '0, '0, '0, '0, '0, '0), 1'b1);
    // Partial then inside stays partial
    send_plane(make_item(One, '0, '0, '0, -One, '0, '0, One, '0, '0), 1'b0);
    send_plane(make_item('0, '0, '0, One, -One, '0, '0, One, '0, '0), 1'b1);
    // Three planes all inside
    send_plane(make_item(One, '0, '0, One, '0, '0, '0, One, One, One), 1'b0);
    send_plane(make_item('0, One, '0, One, '0, '0, '0, One, One, One), 1'b0);
    send_plane(make_item('0, '0, One, One, '0, '0, '0, One, One, One), 1'b1);
    // Box changes within the query
    send_plane(make_item('0, One, '0, '0, '0, '0, '0, '0, One, '0), 1'b0);
    send_plane(make_item('0, One, '0, '0, '0, -2 * One, '0, '0, -One, '0), 1'b1);

    // Random queries, with a burst phase that includes the output hold-off
    while (sent_count < ItemTarget) begin
      if (sent_count >= 500 && sent_count < 1100) begin
        if (idle_pct != 0) begin
          idle_pct     = 0;
          hold_request = 1'b1;
        end
      end else begin
        idle_pct = IdlePct;
      end
      send_random_query();
    end
    in_valid <= 1'b0;

    // Drain
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bcf_pkg.sv
rtl/core/bcf_mul.sv
rtl/core/bcf_partial.sv
rtl/core/bcf_sign.sv
rtl/core/bcf_verdict.sv
rtl/core/box_corner_frustum_classify.sv
tb/tb.sv
